>>> design/cpms_pkg.sv
// Package for the context pool: widths, codes and the request/result types.
// No dependencies.
`timescale 1ns / 1ps
package cpms_pkg;
  localparam int NumPools  = 4;
  localparam int PoolDepth = 1024;
  localparam int PoolW     = $clog2(NumPools);
  localparam int IdxW      = $clog2(PoolDepth);
  localparam int IdW       = $clog2(PoolDepth + 1);
  localparam int AddrW     = PoolW + IdxW;
  localparam int Entries   = NumPools * PoolDepth;
  localparam int SizeW     = 11;

  localparam logic [2:0] FUNC_INIT   = 3'd0;
  localparam logic [2:0] FUNC_ALLOC  = 3'd1;
  localparam logic [2:0] FUNC_ALLOCB = 3'd2;
  localparam logic [2:0] FUNC_MARK   = 3'd3;
  localparam logic [2:0] FUNC_SWEEP  = 3'd4;
  localparam logic [2:0] FUNC_READ   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOFREE  = 2'd2;
  localparam logic [1:0] ST_BAD_ID  = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  table_req;
    logic [10:0] entry_id;
    logic [15:0] call_index;
    logic [31:0] owner;
    logic [31:0] tail_id;
  } req_t;

  typedef struct packed {
    logic [10:0] result_id;
    logic [15:0] out_call_index;
    logic [31:0] out_owner;
    logic [31:0] out_tail_id;
    logic [1:0]  status;
  } rsp_t;
endpackage

>>> design/cpms_req_if.sv
// Request channel: valid/ready plus request payload. Uses cpms_pkg.
`timescale 1ns / 1ps
interface cpms_req_if;
  import cpms_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/cpms_rsp_if.sv
// Result channel: valid/ready plus result payload. Uses cpms_pkg.
`timescale 1ns / 1ps
interface cpms_rsp_if;
  import cpms_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/context_pool_mark_sweep.sv
// Context pool allocator with mark/sweep reclamation, top level.
// Depends on cpms_pkg, cpms_req_if, cpms_rsp_if.
//
//  channel  | dir | payload
//  req      | in  | func, table_req, entry_id, call_index, owner, tail_id
//  rsp      | out | result_id, out_call_index, out_owner, out_tail_id, status
//  cfg      | in  | cfg_we, cfg_data (pool_size)
//
// Allocate, mark and read: accept with memory read, update, then hand-off;
// the result is offered from an output register in the cycle after the hand-off.
// Init writes each link in turn. Sweep reads and checks each entry in turn; a
// pending link patch is written in the read step or the hand-off, not the check.
// Reset clears the free heads and sets pool_size to 1024; no clearing pass. The
// hand-off waits only while the output register still holds an untaken result.
`timescale 1ns / 1ps
module context_pool_mark_sweep (
  input  logic clk,
  input  logic rst,
  cpms_req_if.sink   req,
  cpms_rsp_if.source rsp,
  input  logic                       cfg_we,
  input  logic [cpms_pkg::SizeW-1:0] cfg_data
);
  import cpms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_INIT, S_SW_RD, S_SW_CHK, S_OUT
  } state_t;

  state_t state;
  logic [SizeW-1:0] pool_size;
  logic [IdW-1:0] free_head [NumPools];
  req_t cur;
  rsp_t res;
  rsp_t out_data;
  logic out_valid;

  // link + mark memory, payload memory
  logic [IdW:0]  lm_mem [Entries];
  logic [79:0]   pl_mem [Entries];
  logic [IdW:0]  lm_q;
  logic [79:0]   pl_q;

  logic [IdW-1:0] cnt;
  logic [IdW-1:0] first, last;
  logic [IdW-1:0] size;
  logic [PoolW-1:0] pool;
  logic id_ok;

  // pending link patch: next_link[patch_idx-1] = patch_val
  logic patch;
  logic [IdW-1:0] patch_idx;
  logic [IdW-1:0] patch_val;

  always_comb begin
    size = IdW'(pool_size);
    if (pool_size == '0) size = IdW'(1);
    if (pool_size > SizeW'(PoolDepth)) size = IdW'(PoolDepth);
  end

  assign pool  = cur.table_req[PoolW-1:0];
  assign id_ok = (cur.entry_id != '0) && (IdW'(cur.entry_id) <= size);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  function automatic logic [AddrW-1:0] addr(input logic [PoolW-1:0] p,
                                            input logic [IdW-1:0] i);
    return {p, i[IdxW-1:0]};
  endfunction

  logic [IdW-1:0] hd;
  assign hd = free_head[pool];

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      lm_q <= lm_mem[addr(req.data.table_req[PoolW-1:0],
                          IdW'(req.data.func == FUNC_MARK || req.data.func == FUNC_READ ?
                               req.data.entry_id : free_head[req.data.table_req[PoolW-1:0]])
                          - IdW'(1))];
      pl_q <= pl_mem[addr(req.data.table_req[PoolW-1:0], IdW'(req.data.entry_id) - IdW'(1))];
    end else if (state == S_SW_RD) begin
      lm_q <= lm_mem[addr(pool, cnt)];
    end
    if (state == S_OP && (cur.func == FUNC_ALLOC) && hd != '0)
      pl_mem[addr(pool, hd - IdW'(1))] <= {cur.call_index, cur.owner, cur.tail_id};
    if (state == S_OP && cur.func == FUNC_MARK && id_ok) begin
      lm_mem[addr(pool, IdW'(cur.entry_id) - IdW'(1))] <= {1'b1, lm_q[IdW-1:0]};
    end else if (state == S_INIT) begin
      lm_mem[addr(pool, cnt)] <= {1'b0, (cnt + IdW'(1) < size) ? cnt + IdW'(2) : IdW'(0)};
    end else if (state == S_SW_CHK) begin
      if (!lm_q[IdW]) lm_mem[addr(pool, cnt)] <= '0;
      else lm_mem[addr(pool, cnt)] <= {1'b0, lm_q[IdW-1:0]};
    end else if (patch && (state == S_SW_RD || state == S_OUT)) begin
      lm_mem[addr(pool, patch_idx - IdW'(1))] <= {1'b0, patch_val};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pool_size <= SizeW'(1024);
      for (int p = 0; p < NumPools; p++) free_head[p] <= '0;
      patch <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) pool_size <= cfg_data;
      if (state == S_OUT && (!out_valid || rsp.ready)) begin
        out_data <= res;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (req.valid) begin
          cur <= req.data;
          cnt <= '0;
          first <= '0;
          last <= '0;
          patch <= 1'b0;
          res <= '0;
          if (req.data.func == FUNC_INIT) state <= S_INIT;
          else if (req.data.func == FUNC_SWEEP) state <= S_SW_RD;
          else state <= S_OP;
        end
        S_OP: begin
          case (cur.func) inside
            FUNC_ALLOC, FUNC_ALLOCB: begin
              if (hd == '0 || hd > IdW'(PoolDepth)) res.status <= ST_EMPTY;
              else begin
                res.result_id <= hd;
                free_head[pool] <= (lm_q[IdW-1:0] > IdW'(PoolDepth)) ? '0 : lm_q[IdW-1:0];
              end
            end
            FUNC_MARK: if (!id_ok) res.status <= ST_BAD_ID;
            FUNC_READ: begin
              if (id_ok) {res.out_call_index, res.out_owner, res.out_tail_id} <= pl_q;
              else res.status <= ST_BAD_ID;
            end
            default: ;
          endcase
          state <= S_OUT;
        end
        S_INIT: begin
          cnt <= cnt + IdW'(1);
          if (cnt + IdW'(1) == size) begin
            free_head[pool] <= IdW'(1);
            state <= S_OUT;
          end
        end
        S_SW_RD: begin
          patch <= 1'b0;
          state <= S_SW_CHK;
        end
        S_SW_CHK: begin
          if (!lm_q[IdW]) begin
            if (last == '0) first <= cnt + IdW'(1);
            else begin
              patch <= 1'b1;
              patch_idx <= last;
              patch_val <= cnt + IdW'(1);
            end
            last <= cnt + IdW'(1);
          end
          cnt <= cnt + IdW'(1);
          if (cnt + IdW'(1) == size) state <= S_OUT;
          else state <= S_SW_RD;
          if (cnt + IdW'(1) == size) begin
            if (first == '0 && lm_q[IdW]) res.status <= ST_NOFREE;
            else free_head[pool] <= (first == '0) ? cnt + IdW'(1) : first;
          end
        end
        S_OUT: begin
          patch <= 1'b0;
          if (!out_valid || rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> tb/tb_context_pool_mark_sweep.sv
// Testbench for context_pool_mark_sweep: a queued request driver, a result monitor, and
// a pool model that predicts every result. Uses cpms_pkg, cpms_req_if, cpms_rsp_if and the RTL.
`timescale 1ns / 1ps
module tb_context_pool_mark_sweep;
  import cpms_pkg::*;

  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [SizeW-1:0] cfg_data;

  cpms_req_if req ();
  cpms_rsp_if rsp ();

  context_pool_mark_sweep i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // pool model
  int unsigned size_reg = 1024;
  int unsigned head_q [NumPools];
  int unsigned link_q [Entries];
  bit          mark_q [Entries];
  bit          mark_known [Entries];
  bit          pay_known [Entries];
  logic [15:0] ci_q [Entries];
  logic [31:0] own_q [Entries];
  logic [31:0] tail_q [Entries];
  int          written_q [$];

  req_t pend_req [$];
  rsp_t want_rsp [$];

  int errors = 0;
  int n_req = 0, n_alloc = 0, n_empty = 0, n_sweep = 0, n_nofree = 0, n_bad = 0, n_read = 0;
  int n_sizes = 0;
  bit quiet = 1'b0;
  bit choke_req = 1'b0;
  bit choke_done;
  int gap_in, stall_out;

  function automatic int unsigned eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > PoolDepth) return PoolDepth;
    return size_reg;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic pool_apply(input req_t r);
    rsp_t e;
    int unsigned p, base, sz, id, hd, nx, first, last;
    bit ok;
    e = '0;
    p = r.table_req % NumPools;
    base = p * PoolDepth;
    sz = eff_size();
    id = r.entry_id;
    ok = (id != 0) && (id <= sz);
    n_req++;
    case (r.func)
      FUNC_INIT: begin
        for (int i = 0; i < sz; i++) begin
          link_q[base + i] = (i + 1 < sz) ? i + 2 : 0;
          mark_q[base + i] = 1'b0;
          mark_known[base + i] = 1'b1;
        end
        head_q[p] = 1;
      end
      FUNC_ALLOC, FUNC_ALLOCB: begin
        n_alloc++;
        hd = head_q[p];
        if (hd == 0 || hd > PoolDepth) begin
          e.status = ST_EMPTY;
          n_empty++;
        end else begin
          nx = link_q[base + hd - 1];
          head_q[p] = (nx > PoolDepth) ? 0 : nx;
          if (r.func == FUNC_ALLOC) begin
            ci_q[base + hd - 1] = r.call_index;
            own_q[base + hd - 1] = r.owner;
            tail_q[base + hd - 1] = r.tail_id;
            if (!pay_known[base + hd - 1]) written_q.push_back(base + hd - 1);
            pay_known[base + hd - 1] = 1'b1;
          end
          e.result_id = 11'(hd);
        end
      end
      FUNC_MARK: begin
        if (ok) begin
          mark_q[base + id - 1] = 1'b1;
          mark_known[base + id - 1] = 1'b1;
        end else begin
          e.status = ST_BAD_ID;
          n_bad++;
        end
      end
      FUNC_SWEEP: begin
        n_sweep++;
        first = 0;
        last = 0;
        for (int i = 0; i < sz; i++) begin
          if (!mark_q[base + i]) begin
            if (last == 0) first = i + 1;
            else link_q[base + last - 1] = i + 1;
            link_q[base + i] = 0;
            last = i + 1;
          end
          mark_q[base + i] = 1'b0;
        end
        if (first == 0) begin
          e.status = ST_NOFREE;
          n_nofree++;
        end else begin
          head_q[p] = first;
        end
      end
      FUNC_READ: begin
        n_read++;
        if (ok) begin
          e.out_call_index = ci_q[base + id - 1];
          e.out_owner = own_q[base + id - 1];
          e.out_tail_id = tail_q[base + id - 1];
        end else begin
          e.status = ST_BAD_ID;
          n_bad++;
        end
      end
      default: ;
    endcase
    want_rsp.push_back(e);
  endtask

  task automatic check_rsp(input rsp_t a);
    rsp_t e;
    if (want_rsp.size() == 0) begin
      $display("%0t: unexpected result %h", $time, a);
      errors++;
      return;
    end
    e = want_rsp.pop_front();
    if (a.result_id !== e.result_id) begin
      $display("%0t: result_id exp %0d got %0d", $time, e.result_id, a.result_id);
      errors++;
    end
    if (a.out_call_index !== e.out_call_index) begin
      $display("%0t: call_index exp %h got %h", $time, e.out_call_index, a.out_call_index);
      errors++;
    end
    if (a.out_owner !== e.out_owner) begin
      $display("%0t: owner exp %h got %h", $time, e.out_owner, a.out_owner);
      errors++;
    end
    if (a.out_tail_id !== e.out_tail_id) begin
      $display("%0t: tail_id exp %h got %h", $time, e.out_tail_id, a.out_tail_id);
      errors++;
    end
    if (a.status !== e.status) begin
      $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
      errors++;
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      gap_in <= 0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) pool_apply(req.data);
      if (gap_in > 0) begin
        gap_in <= gap_in - 1;
        req.valid <= 1'b0;
      end else if (pend_req.size() != 0) begin
        req.data <= pend_req.pop_front();
        req.valid <= 1'b1;
        gap_in <= pick_gap();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_out <= 0;
      choke_done <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) check_rsp(rsp.data);
      if (choke_req && !choke_done) begin
        choke_done <= 1'b1;
        stall_out <= 400;
        rsp.ready <= 1'b0;
      end else if (stall_out > 0) begin
        stall_out <= stall_out - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (rsp.valid && rsp.ready) stall_out <= pick_gap();
      end
    end
  end

  task automatic add_req(input logic [2:0] f, input int p, input int id,
                         input int unsigned ci, input int unsigned own,
                         input int unsigned tl);
    req_t r;
    r.func = f;
    r.table_req = 2'(p);
    r.entry_id = 11'(id);
    r.call_index = 16'(ci);
    r.owner = own;
    r.tail_id = tl;
    pend_req.push_back(r);
  endtask

  task automatic drain();
    while (pend_req.size() != 0 || req.valid || want_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_size(input int unsigned v);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= SizeW'(v);
    size_reg = v;
    n_sizes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic bit sweep_safe(input int p);
    for (int i = 0; i < eff_size(); i++)
      if (!mark_known[p * PoolDepth + i]) return 0;
    return 1;
  endfunction

  // one burst of random requests, mostly aimed at one pool
  task automatic random_burst(input int cnt);
    int focus, p, r, w, sz;
    bit safe [NumPools];
    sz = eff_size();
    focus = $urandom_range(0, NumPools - 1);
    for (int i = 0; i < NumPools; i++) safe[i] = sweep_safe(i);
    for (int k = 0; k < cnt; k++) begin
      p = ($urandom_range(0, 9) < 8) ? focus : $urandom_range(0, NumPools - 1);
      r = $urandom_range(0, 99);
      if (head_q[p] == 0 && !safe[p] && r < 50) r = 99;
      if (r < 35) begin
        add_req(FUNC_ALLOC, p, $urandom_range(0, 2047), $urandom, $urandom, $urandom);
      end else if (r < 43) begin
        add_req(FUNC_ALLOCB, p, $urandom_range(0, 2047), $urandom, $urandom, $urandom);
      end else if (r < 63) begin
        if ($urandom_range(0, 9) == 0) add_req(FUNC_MARK, p, $urandom_range(0, 2047), 0, 0, 0);
        else add_req(FUNC_MARK, p, $urandom_range(1, sz), $urandom, $urandom, $urandom);
      end else if (r < 83) begin
        if (written_q.size() != 0 && $urandom_range(0, 9) != 0) begin
          w = written_q[$urandom_range(0, written_q.size() - 1)];
          add_req(FUNC_READ, w / PoolDepth, w % PoolDepth + 1, $urandom, $urandom, $urandom);
        end else begin
          add_req(FUNC_READ, p, ($urandom_range(0, 1) != 0 || sz == PoolDepth) ?
                  (($urandom_range(0, 1) != 0) ? 0 : $urandom_range(PoolDepth + 1, 2047)) :
                  $urandom_range(sz + 1, 2047), $urandom, $urandom, $urandom);
        end
      end else if (r < 90) begin
        if (safe[p]) add_req(FUNC_SWEEP, p, $urandom_range(0, 2047), 0, 0, 0);
        else begin
          add_req(FUNC_INIT, p, 0, 0, 0, 0);
          safe[p] = 1'b1;
        end
      end else if (r < 95) begin
        add_req(($urandom_range(0, 1) != 0) ? FUNC_RSVD6 : FUNC_RSVD7, p,
                $urandom_range(0, 2047), $urandom, $urandom, $urandom);
      end else begin
        add_req(FUNC_INIT, p, $urandom_range(0, 2047), 0, 0, 0);
        safe[p] = 1'b1;
      end
    end
  endtask

  task automatic random_phase(input int total);
    int left, n;
    left = total;
    while (left > 0) begin
      n = (left < 30) ? left : $urandom_range(10, 30);
      quiet = ($urandom_range(0, 3) == 0);
      random_burst(n);
      left -= n;
      drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    random_phase(60);

    // directed: a pool of four entries
    set_size(4);
    add_req(FUNC_ALLOC, 0, 0, 16'h1234, 32'h1, 32'h2);
    add_req(FUNC_INIT, 0, 0, 0, 0, 0);
    add_req(FUNC_ALLOC, 0, 0, 16'h0000, 32'h0, 32'h0);
    add_req(FUNC_ALLOC, 0, 0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(FUNC_ALLOC, 0, 0, 16'hA5A5, 32'h5A5A_5A5A, 32'hC3C3_C3C3);
    add_req(FUNC_ALLOCB, 0, 0, 0, 0, 0);
    add_req(FUNC_ALLOC, 0, 0, 16'h7777, 32'h7, 32'h7);
    add_req(FUNC_READ, 0, 1, 0, 0, 0);
    add_req(FUNC_READ, 0, 2, 0, 0, 0);
    add_req(FUNC_READ, 0, 0, 0, 0, 0);
    add_req(FUNC_READ, 0, 5, 0, 0, 0);
    add_req(FUNC_MARK, 0, 2, 0, 0, 0);
    add_req(FUNC_MARK, 0, 0, 0, 0, 0);
    add_req(FUNC_MARK, 0, 2047, 0, 0, 0);
    add_req(FUNC_SWEEP, 0, 0, 0, 0, 0);
    add_req(FUNC_MARK, 0, 1, 0, 0, 0);
    add_req(FUNC_ALLOCB, 0, 0, 0, 0, 0);
    add_req(FUNC_ALLOCB, 0, 0, 0, 0, 0);
    for (int i = 1; i <= 4; i++) add_req(FUNC_MARK, 0, i, 0, 0, 0);
    add_req(FUNC_SWEEP, 0, 0, 0, 0, 0);
    add_req(FUNC_INIT, 3, 0, 0, 0, 0);
    add_req(FUNC_RSVD6, 3, 4, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(FUNC_RSVD7, 3, 1, 0, 0, 0);
    drain();
    random_phase(60);

    // long hold-off on the result side while requests keep coming
    quiet = 1'b1;
    random_burst(30);
    @(negedge clk);
    choke_req = 1'b1;
    drain();

    set_size(1);
    random_phase(40);
    set_size(0);
    random_phase(30);
    set_size(2047);
    random_phase(70);
    set_size(16);
    random_phase(100);
    set_size(37);
    random_phase(80);
    set_size(1024);
    random_phase(40);
    set_size(8);
    random_phase(50);
    set_size(2);
    random_phase(30);

    drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d requests over %0d pool sizes: %0d allocs (%0d exhausted), %0d reads,",
             n_req, n_sizes + 1, n_alloc, n_empty, n_read);
    $display("  %0d sweeps (%0d freed nothing), %0d bad ids, %0d mismatches.",
             n_sweep, n_nofree, n_bad, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", want_rsp.size());
    $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> sim.f
design/cpms_pkg.sv
design/cpms_req_if.sv
design/cpms_rsp_if.sv
design/context_pool_mark_sweep.sv
tb/tb_context_pool_mark_sweep.sv
